// ===== design/psx_pkg.sv =====
// shared types and constants of the progressive scale expansion block
`default_nettype none
package psx_pkg;

    // fixed field widths
    localparam int SEED_W      = 8;
    localparam int MASK_W      = 7;
    localparam int CFG_W       = 10;
    localparam int KCFG_W      = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int ROUND_W     = 3;
    localparam int MAX_KERNELS = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_KERNELS  = 2'd2;

    // command kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // neighbour order
    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    // classification of a queued command
    typedef struct packed {
        logic kind;
        logic last_img;
        logic last_pix;
    } t_cmd_ctl;

    // back end sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_ROUND,
        S_POP_WAIT,
        S_LBL,
        S_NB,
        S_NB_CHK,
        S_PARK
    } t_state;

endpackage
`default_nettype wire

// ===== design/psx_ram.sv =====
// generic simple dual port ram with registered read
`default_nettype none
module psx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== design/psx_front.sv =====
// front end: accepts commands, assigns pixel positions, queues them
`default_nettype none
module psx_front #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
    localparam int NW    = $clog2(DEPTH + 1),
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic                       i_kind,
    input  wire logic [psx_pkg::SEED_W-1:0] i_seed_label,
    input  wire logic [psx_pkg::MASK_W-1:0] i_kernel_mask,
    input  wire logic [NW-1:0]              i_total,
    output logic                            o_busy,
    output logic                            o_cmd_valid,
    output psx_pkg::t_cmd_ctl               o_cmd_ctl,
    output logic [AW-1:0]                   o_cmd_addr,
    output logic [psx_pkg::SEED_W-1:0]      o_cmd_seed,
    output logic [psx_pkg::MASK_W-1:0]      o_cmd_mask,
    input  wire logic                       i_cmd_pop
);

    localparam int FD  = 4;
    localparam int FPW = 2;
    localparam int FCW = 3;

    logic [NW-1:0]  r_load_pos, n_load_pos;
    logic [NW-1:0]  r_read_pos, n_read_pos;
    logic [FPW-1:0] r_wr_ptr, r_rd_ptr;
    logic [FCW-1:0] r_fcnt;

    psx_pkg::t_cmd_ctl         r_f_ctl  [FD];
    logic [AW-1:0]             r_f_addr [FD];
    logic [psx_pkg::SEED_W-1:0] r_f_seed [FD];
    logic [psx_pkg::MASK_W-1:0] r_f_mask [FD];

    logic              w_accept;
    logic [NW-1:0]     w_lpos, w_lnext, w_rpos;
    logic              w_lend, w_rlast;
    psx_pkg::t_cmd_ctl w_ctl;
    logic [AW-1:0]     w_addr;

    assign o_busy   = (r_fcnt == FCW'(FD));
    assign w_accept = i_start & ~o_busy;

    // position classification, wrapping when the image size shrank
    always_comb begin
        w_lpos  = (r_load_pos >= i_total) ? '0 : r_load_pos;
        w_lnext = w_lpos + NW'(1);
        w_lend  = (w_lnext >= i_total);
        w_rpos  = (r_read_pos >= i_total) ? '0 : r_read_pos;
        w_rlast = (w_rpos == i_total - NW'(1));
        n_load_pos = r_load_pos;
        n_read_pos = r_read_pos;
        w_ctl.kind     = i_kind;
        w_ctl.last_img = 1'b0;
        w_ctl.last_pix = 1'b0;
        if (i_kind == psx_pkg::KIND_LOAD) begin
            w_addr = w_lpos[AW-1:0];
            w_ctl.last_img = w_lend;
            if (w_accept) begin
                n_load_pos = w_lend ? '0 : w_lnext;
                if (w_lend) begin
                    n_read_pos = '0;
                end
            end
        end else begin
            w_addr = w_rpos[AW-1:0];
            w_ctl.last_pix = w_rlast;
            if (w_accept) begin
                n_read_pos = w_rlast ? '0 : (w_rpos + NW'(1));
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_pos <= '0;
            r_read_pos <= '0;
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fcnt     <= '0;
        end else begin
            r_load_pos <= n_load_pos;
            r_read_pos <= n_read_pos;
            if (w_accept) begin
                r_wr_ptr <= r_wr_ptr + FPW'(1);
            end
            if (i_cmd_pop) begin
                r_rd_ptr <= r_rd_ptr + FPW'(1);
            end
            r_fcnt <= r_fcnt + FCW'(w_accept) - FCW'(i_cmd_pop);
        end
    end

    // command queue payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_f_ctl[r_wr_ptr]  <= w_ctl;
            r_f_addr[r_wr_ptr] <= w_addr;
            r_f_seed[r_wr_ptr] <= i_seed_label;
            r_f_mask[r_wr_ptr] <= i_kernel_mask;
        end
    end

    assign o_cmd_valid = (r_fcnt != '0);
    assign o_cmd_ctl   = r_f_ctl[r_rd_ptr];
    assign o_cmd_addr  = r_f_addr[r_rd_ptr];
    assign o_cmd_seed  = r_f_seed[r_rd_ptr];
    assign o_cmd_mask  = r_f_mask[r_rd_ptr];

    property p_no_overflow;
        @(posedge i_clk) disable iff (!i_rst_n) r_fcnt <= FCW'(FD);
    endproperty
    a_no_overflow: assert property (p_no_overflow) else $error("command queue overflow");

    property p_pop_nonempty;
        @(posedge i_clk) disable iff (!i_rst_n) i_cmd_pop |-> o_cmd_valid;
    endproperty
    a_pop_nonempty: assert property (p_pop_nonempty) else $error("pop from empty queue");

    property p_count_track;
        @(posedge i_clk) disable iff (!i_rst_n)
            (w_accept && !i_cmd_pop) |=> (r_fcnt == $past(r_fcnt) + FCW'(1));
    endproperty
    a_count_track: assert property (p_count_track) else $error("queue count mismatch");

endmodule
`default_nettype wire

// ===== design/psx_back.sv =====
// back end: label store, readout and round-by-round expansion engine
`default_nettype none
module psx_back #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
    localparam int NW    = $clog2(DEPTH + 1),
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int WW    = $clog2(MAX_WIDTH + 1),
    localparam int HW    = $clog2(MAX_HEIGHT + 1)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cmd_valid,
    input  wire psx_pkg::t_cmd_ctl           i_cmd_ctl,
    input  wire logic [AW-1:0]               i_cmd_addr,
    input  wire logic [psx_pkg::SEED_W-1:0]  i_cmd_seed,
    input  wire logic [psx_pkg::MASK_W-1:0]  i_cmd_mask,
    output logic                             o_cmd_pop,
    input  wire logic [WW-1:0]               i_width,
    input  wire logic [HW-1:0]               i_height,
    input  wire logic [NW-1:0]               i_total,
    input  wire logic [psx_pkg::ROUND_W-1:0] i_rounds,
    output logic                             o_valid,
    output logic [psx_pkg::SEED_W-1:0]       o_region_label,
    output logic                             o_last_pixel
);

    localparam int SW = psx_pkg::SEED_W + psx_pkg::MASK_W;
    localparam int QW = WW + HW + AW;

    psx_pkg::t_state r_state, n_state;

    logic [NW-1:0] r_fill, n_fill;
    logic [NW-1:0] r_scan_p, n_scan_p;
    logic [WW-1:0] r_scan_x, n_scan_x;
    logic [HW-1:0] r_scan_y, n_scan_y;
    logic          r_sel, n_sel;
    logic [NW-1:0] r_cnt, n_cnt;
    logic [NW-1:0] r_head, n_head;
    logic [NW-1:0] r_ncnt, n_ncnt;
    logic [psx_pkg::ROUND_W-1:0] r_bit, n_bit;
    logic [1:0]    r_dir, n_dir;
    logic          r_claimed, n_claimed;
    logic          r_valid, n_valid;

    logic [WW-1:0] r_px, n_px, r_nx, n_nx;
    logic [HW-1:0] r_py, n_py, r_ny, n_ny;
    logic [AW-1:0] r_pa, n_pa, r_np, n_np;
    logic [psx_pkg::SEED_W-1:0] r_lab, n_lab, r_label, n_label;
    logic          r_rd_hit, n_rd_hit, r_rd_last, n_rd_last, r_last, n_last;

    logic          s_we;
    logic [AW-1:0] s_waddr, s_raddr;
    logic [SW-1:0] s_wdata, s_rdata;
    logic [1:0]    q_we;
    logic [AW-1:0] q_waddr, q_raddr;
    logic [QW-1:0] q_wdata, q_rdata0, q_rdata1, w_q;

    logic          w_nb_ok, w_claim, w_scan_end, w_round_end;
    logic [WW-1:0] w_nb_x;
    logic [HW-1:0] w_nb_y;
    logic [AW-1:0] w_nb_a;
    logic [psx_pkg::MASK_W-1:0] w_kmask;

    // label and kernel bits share one store: {mask, label}
    psx_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_store (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(s_rdata)
    );

    // two position queues, roles swap every round
    psx_ram #(.WIDTH(QW), .DEPTH(DEPTH)) u_queue0 (
        .i_clk(i_clk), .i_we(q_we[0]), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_raddr(q_raddr), .o_rdata(q_rdata0)
    );
    psx_ram #(.WIDTH(QW), .DEPTH(DEPTH)) u_queue1 (
        .i_clk(i_clk), .i_we(q_we[1]), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_raddr(q_raddr), .o_rdata(q_rdata1)
    );

    // neighbour geometry and claim test
    always_comb begin
        w_q     = r_sel ? q_rdata1 : q_rdata0;
        w_kmask = s_rdata[psx_pkg::SEED_W +: psx_pkg::MASK_W];
        w_claim = w_kmask[r_bit] && (s_rdata[psx_pkg::SEED_W-1:0] == '0);
        w_scan_end  = (r_scan_p + NW'(1) == i_total);
        w_round_end = (r_head == r_cnt);
        w_nb_x = r_px;
        w_nb_y = r_py;
        w_nb_a = r_pa;
        w_nb_ok = 1'b0;
        unique case (r_dir)
            psx_pkg::DIR_LEFT: begin
                w_nb_ok = (r_px != '0);
                w_nb_x  = r_px - WW'(1);
                w_nb_a  = r_pa - AW'(1);
            end
            psx_pkg::DIR_RIGHT: begin
                w_nb_ok = (r_px + WW'(1) != i_width);
                w_nb_x  = r_px + WW'(1);
                w_nb_a  = r_pa + AW'(1);
            end
            psx_pkg::DIR_UP: begin
                w_nb_ok = (r_py != '0);
                w_nb_y  = r_py - HW'(1);
                w_nb_a  = r_pa - AW'(i_width);
            end
            psx_pkg::DIR_DOWN: begin
                w_nb_ok = (r_py + HW'(1) != i_height);
                w_nb_y  = r_py + HW'(1);
                w_nb_a  = r_pa + AW'(i_width);
            end
            default: w_nb_ok = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            psx_pkg::S_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd_ctl.kind == psx_pkg::KIND_READ) begin
                        n_state = psx_pkg::S_READ;
                    end else if (i_cmd_ctl.last_img) begin
                        n_state = psx_pkg::S_SCAN_RD;
                    end
                end
            end
            psx_pkg::S_READ:    n_state = psx_pkg::S_IDLE;
            psx_pkg::S_SCAN_RD: n_state = psx_pkg::S_SCAN_CHK;
            psx_pkg::S_SCAN_CHK: begin
                if (!w_scan_end) begin
                    n_state = psx_pkg::S_SCAN_RD;
                end else if (i_rounds == '0) begin
                    n_state = psx_pkg::S_IDLE;
                end else begin
                    n_state = psx_pkg::S_ROUND;
                end
            end
            psx_pkg::S_ROUND: begin
                if (!w_round_end) begin
                    n_state = psx_pkg::S_POP_WAIT;
                end else if (r_bit + psx_pkg::ROUND_W'(1) == i_rounds) begin
                    n_state = psx_pkg::S_IDLE;
                end
            end
            psx_pkg::S_POP_WAIT: n_state = psx_pkg::S_LBL;
            psx_pkg::S_LBL:      n_state = psx_pkg::S_NB;
            psx_pkg::S_NB: begin
                if (w_nb_ok) begin
                    n_state = psx_pkg::S_NB_CHK;
                end else if (r_dir == psx_pkg::DIR_DOWN) begin
                    n_state = psx_pkg::S_PARK;
                end
            end
            psx_pkg::S_NB_CHK: begin
                n_state = (r_dir == psx_pkg::DIR_DOWN) ? psx_pkg::S_PARK : psx_pkg::S_NB;
            end
            psx_pkg::S_PARK: n_state = psx_pkg::S_ROUND;
            default:         n_state = psx_pkg::S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_fill = r_fill;  n_scan_p = r_scan_p; n_scan_x = r_scan_x; n_scan_y = r_scan_y;
        n_sel = r_sel;    n_cnt = r_cnt;       n_head = r_head;     n_ncnt = r_ncnt;
        n_bit = r_bit;    n_dir = r_dir;       n_claimed = r_claimed;
        n_valid = 1'b0;
        n_px = r_px; n_py = r_py; n_pa = r_pa; n_nx = r_nx; n_ny = r_ny; n_np = r_np;
        n_lab = r_lab; n_label = r_label; n_last = r_last;
        n_rd_hit = r_rd_hit; n_rd_last = r_rd_last;
        o_cmd_pop = 1'b0;
        s_we    = 1'b0;
        s_waddr = i_cmd_addr;
        s_wdata = {i_cmd_mask, i_cmd_seed};
        s_raddr = i_cmd_addr;
        q_we    = 2'b00;
        q_waddr = r_cnt[AW-1:0];
        q_wdata = {r_scan_x, r_scan_y, r_scan_p[AW-1:0]};
        q_raddr = r_head[AW-1:0];
        unique case (r_state)
            // take one command from the queue
            psx_pkg::S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd_ctl.kind == psx_pkg::KIND_LOAD) begin
                        s_we   = 1'b1;
                        n_fill = NW'(i_cmd_addr) + NW'(1);
                        if (i_cmd_ctl.last_img) begin
                            n_scan_p = '0;
                            n_scan_x = '0;
                            n_scan_y = '0;
                            n_cnt    = '0;
                            n_sel    = 1'b0;
                        end
                    end else begin
                        n_rd_hit  = (NW'(i_cmd_addr) < r_fill);
                        n_rd_last = i_cmd_ctl.last_pix;
                    end
                end
            end
            // unwritten entries of this image read as zero
            psx_pkg::S_READ: begin
                n_valid = 1'b1;
                n_label = r_rd_hit ? s_rdata[psx_pkg::SEED_W-1:0] : '0;
                n_last  = r_rd_last;
            end
            psx_pkg::S_SCAN_RD: begin
                s_raddr = r_scan_p[AW-1:0];
            end
            // queue seeds in raster order
            psx_pkg::S_SCAN_CHK: begin
                if (s_rdata[psx_pkg::SEED_W-1:0] != '0) begin
                    q_we[0] = 1'b1;
                    n_cnt   = r_cnt + NW'(1);
                end
                n_scan_p = r_scan_p + NW'(1);
                if (r_scan_x + WW'(1) == i_width) begin
                    n_scan_x = '0;
                    n_scan_y = r_scan_y + HW'(1);
                end else begin
                    n_scan_x = r_scan_x + WW'(1);
                end
                n_head = '0;
                n_ncnt = '0;
                n_bit  = '0;
            end
            // pop or close the round
            psx_pkg::S_ROUND: begin
                if (w_round_end) begin
                    n_sel  = ~r_sel;
                    n_cnt  = r_ncnt;
                    n_head = '0;
                    n_ncnt = '0;
                    n_bit  = r_bit + psx_pkg::ROUND_W'(1);
                end else begin
                    n_head = r_head + NW'(1);
                end
            end
            psx_pkg::S_POP_WAIT: begin
                n_px    = w_q[AW+HW +: WW];
                n_py    = w_q[AW +: HW];
                n_pa    = w_q[0 +: AW];
                s_raddr = w_q[0 +: AW];
            end
            psx_pkg::S_LBL: begin
                n_lab     = s_rdata[psx_pkg::SEED_W-1:0];
                n_dir     = psx_pkg::DIR_LEFT;
                n_claimed = 1'b0;
            end
            psx_pkg::S_NB: begin
                if (w_nb_ok) begin
                    s_raddr = w_nb_a;
                    n_np    = w_nb_a;
                    n_nx    = w_nb_x;
                    n_ny    = w_nb_y;
                end else if (r_dir != psx_pkg::DIR_DOWN) begin
                    n_dir = r_dir + 2'd1;
                end
            end
            // claim an unlabelled neighbour inside this round's kernel
            psx_pkg::S_NB_CHK: begin
                if (w_claim) begin
                    s_we      = 1'b1;
                    s_waddr   = r_np;
                    s_wdata   = {w_kmask, r_lab};
                    q_we      = r_sel ? 2'b10 : 2'b01;
                    q_wdata   = {r_nx, r_ny, r_np};
                    n_cnt     = r_cnt + NW'(1);
                    n_claimed = 1'b1;
                end
                if (r_dir != psx_pkg::DIR_DOWN) begin
                    n_dir = r_dir + 2'd1;
                end
            end
            // a pixel that claimed nothing waits for the next round
            psx_pkg::S_PARK: begin
                if (!r_claimed) begin
                    q_we    = r_sel ? 2'b01 : 2'b10;
                    q_waddr = r_ncnt[AW-1:0];
                    q_wdata = {r_px, r_py, r_pa};
                    n_ncnt  = r_ncnt + NW'(1);
                end
            end
            default: n_valid = 1'b0;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= psx_pkg::S_IDLE;
            r_fill    <= '0;
            r_scan_p  <= '0;
            r_scan_x  <= '0;
            r_scan_y  <= '0;
            r_sel     <= 1'b0;
            r_cnt     <= '0;
            r_head    <= '0;
            r_ncnt    <= '0;
            r_bit     <= '0;
            r_dir     <= psx_pkg::DIR_LEFT;
            r_claimed <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_scan_p  <= n_scan_p;
            r_scan_x  <= n_scan_x;
            r_scan_y  <= n_scan_y;
            r_sel     <= n_sel;
            r_cnt     <= n_cnt;
            r_head    <= n_head;
            r_ncnt    <= n_ncnt;
            r_bit     <= n_bit;
            r_dir     <= n_dir;
            r_claimed <= n_claimed;
            r_valid   <= n_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_px      <= n_px;
        r_py      <= n_py;
        r_pa      <= n_pa;
        r_nx      <= n_nx;
        r_ny      <= n_ny;
        r_np      <= n_np;
        r_lab     <= n_lab;
        r_label   <= n_label;
        r_last    <= n_last;
        r_rd_hit  <= n_rd_hit;
        r_rd_last <= n_rd_last;
    end

    assign o_valid        = r_valid;
    assign o_region_label = r_label;
    assign o_last_pixel   = r_last;

    property p_valid_from_read;
        @(posedge i_clk) disable iff (!i_rst_n) r_valid |-> $past(r_state) == psx_pkg::S_READ;
    endproperty
    a_valid_from_read: assert property (p_valid_from_read) else $error("stray result strobe");

    property p_head_behind_tail;
        @(posedge i_clk) disable iff (!i_rst_n) r_head <= r_cnt;
    endproperty
    a_head_behind_tail: assert property (p_head_behind_tail) else $error("queue head passed tail");

    property p_fill_bound;
        @(posedge i_clk) disable iff (!i_rst_n) r_fill <= NW'(DEPTH);
    endproperty
    a_fill_bound: assert property (p_fill_bound) else $error("fill count beyond store");

    property p_no_pop_busy;
        @(posedge i_clk) disable iff (!i_rst_n) o_cmd_pop |-> r_state == psx_pkg::S_IDLE;
    endproperty
    a_no_pop_busy: assert property (p_no_pop_busy) else $error("command taken while busy");

endmodule
`default_nettype wire

// ===== design/progressive_scale_expansion.sv =====
// top level: configuration registers, command front end and expansion back end
// a load is queued when accepted and written to the store at the edge that takes it off the queue
// a read transaction is popped in idle, its label is read in the read state, and its strobe is registered from there
// the last load of an image starts expansion: a seed scan that reads and checks every pixel, then
//   rounds that pop each queued pixel, read its label and check each in-bounds neighbour
// busy rises when the four-entry command queue is full; results cannot be held off
// synchronous active-low reset clears control state; the label store reads zero by fill count
`default_nettype none
module progressive_scale_expansion #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_kind,
    input  wire logic [psx_pkg::SEED_W-1:0]    i_seed_label,
    input  wire logic [psx_pkg::MASK_W-1:0]    i_kernel_mask,
    input  wire logic                          i_cfg_we,
    input  wire logic [psx_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [psx_pkg::CFG_W-1:0]     i_cfg_wdata,
    output logic                               o_valid,
    output logic [psx_pkg::SEED_W-1:0]         o_region_label,
    output logic                               o_last_pixel
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int NW    = $clog2(DEPTH + 1);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int PW    = WW + HW;

    logic [psx_pkg::CFG_W-1:0]  r_image_width, r_image_height;
    logic [psx_pkg::KCFG_W-1:0] r_num_kernels;

    logic [WW-1:0]               w_width;
    logic [HW-1:0]               w_height;
    logic [psx_pkg::KCFG_W-1:0]  w_kernels;
    logic [psx_pkg::ROUND_W-1:0] w_rounds;
    logic [PW-1:0]               w_prod;
    logic [NW-1:0]               w_total;

    psx_pkg::t_cmd_ctl          w_cmd_ctl;
    logic                       w_cmd_valid, w_cmd_pop;
    logic [AW-1:0]              w_cmd_addr;
    logic [psx_pkg::SEED_W-1:0] w_cmd_seed;
    logic [psx_pkg::MASK_W-1:0] w_cmd_mask;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= 10'd512;
            r_image_height <= 10'd512;
            r_num_kernels  <= 4'd6;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                psx_pkg::CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_wdata;
                psx_pkg::CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_wdata;
                psx_pkg::CFG_NUM_KERNELS:  r_num_kernels  <= i_cfg_wdata[psx_pkg::KCFG_W-1:0];
                default: ;
            endcase
        end
    end

    // clamped geometry and round count
    always_comb begin
        if (r_image_width == '0) begin
            w_width = WW'(1);
        end else if (int'(r_image_width) > MAX_WIDTH) begin
            w_width = WW'(MAX_WIDTH);
        end else begin
            w_width = WW'(r_image_width);
        end
        if (r_image_height == '0) begin
            w_height = HW'(1);
        end else if (int'(r_image_height) > MAX_HEIGHT) begin
            w_height = HW'(MAX_HEIGHT);
        end else begin
            w_height = HW'(r_image_height);
        end
        if (r_num_kernels == '0) begin
            w_kernels = psx_pkg::KCFG_W'(1);
        end else if (int'(r_num_kernels) > psx_pkg::MAX_KERNELS) begin
            w_kernels = psx_pkg::KCFG_W'(psx_pkg::MAX_KERNELS);
        end else begin
            w_kernels = r_num_kernels;
        end
        w_rounds = psx_pkg::ROUND_W'(w_kernels - psx_pkg::KCFG_W'(1));
        w_prod   = PW'(w_width) * PW'(w_height);
        w_total  = NW'(w_prod);
    end

    psx_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_kind       (i_kind),
        .i_seed_label (i_seed_label),
        .i_kernel_mask(i_kernel_mask),
        .i_total      (w_total),
        .o_busy       (busy),
        .o_cmd_valid  (w_cmd_valid),
        .o_cmd_ctl    (w_cmd_ctl),
        .o_cmd_addr   (w_cmd_addr),
        .o_cmd_seed   (w_cmd_seed),
        .o_cmd_mask   (w_cmd_mask),
        .i_cmd_pop    (w_cmd_pop)
    );

    psx_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (w_cmd_valid),
        .i_cmd_ctl     (w_cmd_ctl),
        .i_cmd_addr    (w_cmd_addr),
        .i_cmd_seed    (w_cmd_seed),
        .i_cmd_mask    (w_cmd_mask),
        .o_cmd_pop     (w_cmd_pop),
        .i_width       (w_width),
        .i_height      (w_height),
        .i_total       (w_total),
        .i_rounds      (w_rounds),
        .o_valid       (o_valid),
        .o_region_label(o_region_label),
        .o_last_pixel  (o_last_pixel)
    );

endmodule
`default_nettype wire

// ===== bench/psx_checker.sv =====
// transaction monitor, label expansion predictor and result comparison
`default_nettype none
module psx_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic                          i_busy,
    input  wire logic                          i_kind,
    input  wire logic [psx_pkg::SEED_W-1:0]    i_seed_label,
    input  wire logic [psx_pkg::MASK_W-1:0]    i_kernel_mask,
    input  wire logic                          i_cfg_we,
    input  wire logic [psx_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [psx_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  wire logic                          i_valid,
    input  wire logic [psx_pkg::SEED_W-1:0]    i_region_label,
    input  wire logic                          i_last_pixel,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIX_MAX = 512 * 512;

    typedef struct packed {
        logic [psx_pkg::SEED_W-1:0] label;
        logic                       last;
    } t_pixel_out;

    logic [psx_pkg::SEED_W-1:0]   label_mem [PIX_MAX];
    logic [psx_pkg::MASK_W-1:0]   kmask_mem [PIX_MAX];
    int unsigned                  dirty_top;
    logic [psx_pkg::CFG_W-1:0]    cfg_width, cfg_height;
    logic [psx_pkg::KCFG_W-1:0]   cfg_kernels;
    int unsigned                  load_pos, read_pos;
    t_pixel_out                   pixel_fifo [$];

    function automatic int unsigned eff_w();
        return (cfg_width == 0) ? 1 : (cfg_width > 512) ? 512 : int'(cfg_width);
    endfunction

    function automatic int unsigned eff_h();
        return (cfg_height == 0) ? 1 : (cfg_height > 512) ? 512 : int'(cfg_height);
    endfunction

    function automatic int unsigned eff_k();
        return (cfg_kernels == 0) ? 1 :
               (cfg_kernels > psx_pkg::MAX_KERNELS) ? psx_pkg::MAX_KERNELS : int'(cfg_kernels);
    endfunction

    // grow labels outward, one kernel per round, breadth first
    task automatic grow_labels();
        int unsigned w, h, total, rounds, pos, np;
        int x, y, nx, ny;
        bit claimed;
        int unsigned this_round [$];
        int unsigned carry [$];
        w = eff_w();
        h = eff_h();
        total = w * h;
        rounds = eff_k() - 1;
        for (int unsigned p = 0; p < total; p++)
            if (label_mem[p] != 0) this_round.push_back(p);
        for (int unsigned r = 1; r <= rounds; r++) begin
            carry.delete();
            while (this_round.size() > 0) begin
                pos = this_round.pop_front();
                x = int'(pos % w);
                y = int'(pos / w);
                claimed = 0;
                for (int d = 0; d < 4; d++) begin
                    nx = x + ((d == psx_pkg::DIR_LEFT) ? -1 : (d == psx_pkg::DIR_RIGHT) ? 1 : 0);
                    ny = y + ((d == psx_pkg::DIR_UP) ? -1 : (d == psx_pkg::DIR_DOWN) ? 1 : 0);
                    if (nx < 0 || ny < 0 || nx >= int'(w) || ny >= int'(h)) continue;
                    np = ny * w + nx;
                    if (r - 1 >= psx_pkg::MASK_W) continue;
                    if (kmask_mem[np][r-1] == 1'b0) continue;
                    if (label_mem[np] != 0) continue;
                    label_mem[np] = label_mem[pos];
                    this_round.push_back(np);
                    claimed = 1;
                end
                if (!claimed) carry.push_back(pos);
            end
            this_round = carry;
        end
    endtask

    always @(posedge i_clk) begin
        int unsigned total;
        t_pixel_out want;
        int fails;
        fails = 0;
        if (!i_rst_n) begin
            cfg_width   <= 10'd512;
            cfg_height  <= 10'd512;
            cfg_kernels <= 4'd6;
            load_pos  = 0;
            read_pos  = 0;
            for (int unsigned p = 0; p < PIX_MAX; p++) label_mem[p] = '0;
            dirty_top = 0;
            pixel_fifo.delete();
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            // register writes take effect for the next transaction
            if (i_cfg_we) begin
                case (i_cfg_index)
                    psx_pkg::CFG_IMAGE_WIDTH:  cfg_width   <= i_cfg_wdata;
                    psx_pkg::CFG_IMAGE_HEIGHT: cfg_height  <= i_cfg_wdata;
                    psx_pkg::CFG_NUM_KERNELS:  cfg_kernels <= i_cfg_wdata[psx_pkg::KCFG_W-1:0];
                    default: ;
                endcase
            end
            // accepted command
            if (i_start && !i_busy) begin
                total = eff_w() * eff_h();
                if (i_kind == psx_pkg::KIND_LOAD) begin
                    if (load_pos >= total) load_pos = 0;
                    if (load_pos == 0) begin
                        for (int unsigned p = 0; p < dirty_top; p++) label_mem[p] = '0;
                        dirty_top = 0;
                    end
                    label_mem[load_pos] = i_seed_label;
                    kmask_mem[load_pos] = i_kernel_mask;
                    load_pos++;
                    if (load_pos > dirty_top) dirty_top = load_pos;
                    if (load_pos >= total) begin
                        load_pos = 0;
                        read_pos = 0;
                        if (total > dirty_top) dirty_top = total;
                        grow_labels();
                    end
                end else begin
                    if (read_pos >= total) read_pos = 0;
                    want.label = label_mem[read_pos];
                    want.last  = (read_pos == total - 1);
                    pixel_fifo.push_back(want);
                    read_pos++;
                    if (read_pos >= total) read_pos = 0;
                end
            end
            // returned pixel against oldest prediction
            if (i_valid) begin
                if (pixel_fifo.size() == 0) begin
                    $error("unexpected result: region_label %0d last_pixel %0d",
                           i_region_label, i_last_pixel);
                    fails++;
                end else begin
                    want = pixel_fifo.pop_front();
                    if (i_region_label !== want.label) begin
                        $error("region_label: expected %0d, got %0d", want.label,
                               i_region_label);
                        fails++;
                    end
                    if (i_last_pixel !== want.last) begin
                        $error("last_pixel: expected %0d, got %0d", want.last,
                               i_last_pixel);
                        fails++;
                    end
                end
            end
            o_fail_count <= o_fail_count + fails;
            o_pending    <= pixel_fifo.size();
        end
    end

endmodule
`default_nettype wire

// ===== bench/progressive_scale_expansion_tb.sv =====
// testbench top: clock, reset, command stimulus, register writes and verdict
`default_nettype none
module progressive_scale_expansion_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // register index that selects no register
    localparam logic [psx_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic                          i_kind = psx_pkg::KIND_LOAD;
    logic [psx_pkg::SEED_W-1:0]    i_seed_label = '0;
    logic [psx_pkg::MASK_W-1:0]    i_kernel_mask = '0;
    logic                          i_cfg_we = 1'b0;
    logic [psx_pkg::CFG_IDX_W-1:0] i_cfg_index = psx_pkg::CFG_IMAGE_WIDTH;
    logic [psx_pkg::CFG_W-1:0]     i_cfg_wdata = '0;
    logic                          o_valid;
    logic [psx_pkg::SEED_W-1:0]    o_region_label;
    logic                          o_last_pixel;
    int                            fail_count, pending;

    int  n_loads, n_reads, n_images, n_cfg;
    bit  calm;
    int unsigned cur_w = 512, cur_h = 512, cur_k = 6;

    always #6 i_clk = ~i_clk;

    progressive_scale_expansion dut (
        .i_clk, .i_rst_n, .start, .busy, .i_kind, .i_seed_label, .i_kernel_mask,
        .i_cfg_we, .i_cfg_index, .i_cfg_wdata, .o_valid, .o_region_label, .o_last_pixel
    );

    psx_checker u_checker (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_kind, .i_seed_label,
        .i_kernel_mask, .i_cfg_we, .i_cfg_index, .i_cfg_wdata, .i_valid(o_valid),
        .i_region_label(o_region_label), .i_last_pixel(o_last_pixel),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 70) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // one command transaction, held until accepted
    task automatic issue(logic kind, logic [psx_pkg::SEED_W-1:0] seed,
                         logic [psx_pkg::MASK_W-1:0] mask);
        int gap;
        bit taken;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_kind        <= kind;
        i_seed_label  <= seed;
        i_kernel_mask <= mask;
        do begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end while (!taken);
        if (kind == psx_pkg::KIND_LOAD) n_loads++;
        else n_reads++;
    endtask

    // a random read transaction
    task automatic issue_read();
        issue(psx_pkg::KIND_READ, psx_pkg::SEED_W'($urandom), psx_pkg::MASK_W'($urandom));
    endtask

    // sender pauses until every result is back and expansion has settled
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (16 * cur_w * cur_h * cur_k + 100) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [psx_pkg::CFG_IDX_W-1:0] idx,
                             logic [psx_pkg::CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        n_cfg++;
        case (idx)
            psx_pkg::CFG_IMAGE_WIDTH:  cur_w = (val == 0) ? 1 : (val > 512) ? 512 : val;
            psx_pkg::CFG_IMAGE_HEIGHT: cur_h = (val == 0) ? 1 : (val > 512) ? 512 : val;
            psx_pkg::CFG_NUM_KERNELS:
                cur_k = (val[psx_pkg::KCFG_W-1:0] == 0) ? 1 :
                        (val[psx_pkg::KCFG_W-1:0] > 8) ? 8 : val[psx_pkg::KCFG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_shape(int w, int h, int k);
        write_reg(psx_pkg::CFG_IMAGE_WIDTH, psx_pkg::CFG_W'(w));
        write_reg(psx_pkg::CFG_IMAGE_HEIGHT, psx_pkg::CFG_W'(h));
        write_reg(psx_pkg::CFG_NUM_KERNELS, psx_pkg::CFG_W'(k));
    endtask

    // one random pixel load with mostly nested kernels and a sparse seed
    task automatic load_pixel();
        logic [psx_pkg::SEED_W-1:0] seed;
        logic [psx_pkg::MASK_W-1:0] mask;
        seed = ($urandom_range(0, 9) == 0) ? psx_pkg::SEED_W'($urandom_range(1, 255)) : 8'd0;
        if ($urandom_range(0, 4) == 0) mask = psx_pkg::MASK_W'($urandom_range(0, 127));
        else mask = 7'h7f << $urandom_range(0, 7);
        issue(psx_pkg::KIND_LOAD, seed, mask);
    endtask

    // full image with a few stray reads, then the readout
    task automatic run_image();
        int unsigned total, extra;
        total = cur_w * cur_h;
        extra = $urandom_range(0, 3);
        for (int unsigned p = 0; p < total; p++) begin
            if ($urandom_range(0, 24) == 0) issue_read();
            load_pixel();
        end
        n_images++;
        for (int unsigned p = 0; p < total + extra; p++)
            issue_read();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: unknown index, reads before expansion, wrap, deepest round
        write_reg(CFG_UNUSED, 10'h3ff);
        set_shape(3, 2, 15);
        issue(psx_pkg::KIND_LOAD, 8'hff, 7'h00);
        issue(psx_pkg::KIND_LOAD, 8'h00, 7'h7f);
        issue(psx_pkg::KIND_READ, 8'h00, 7'h00);
        issue(psx_pkg::KIND_READ, 8'hff, 7'h7f);
        issue(psx_pkg::KIND_LOAD, 8'h01, 7'h40);
        issue(psx_pkg::KIND_LOAD, 8'h00, 7'h40);
        issue(psx_pkg::KIND_LOAD, 8'h00, 7'h01);
        issue(psx_pkg::KIND_LOAD, 8'h00, 7'h7f);
        for (int i = 0; i < 8; i++) issue(psx_pkg::KIND_READ, 8'h00, 7'h00);
        // shrink below the read position so it restarts
        drain();
        set_shape(1, 1, 0);
        issue(psx_pkg::KIND_READ, 8'h00, 7'h00);
        issue(psx_pkg::KIND_LOAD, 8'h80, 7'h7f);
        issue(psx_pkg::KIND_READ, 8'h00, 7'h00);
        issue(psx_pkg::KIND_READ, 8'h00, 7'h00);

        // clamped widest and tallest shapes, partly loaded then read back
        drain();
        set_shape(1023, 1, 15);
        for (int i = 0; i < 12; i++) load_pixel();
        for (int i = 0; i < 12; i++) issue_read();
        drain();
        set_shape(1, 1023, 1);
        for (int i = 0; i < 12; i++) load_pixel();
        for (int i = 0; i < 12; i++) issue_read();

        // random shapes and kernel counts, small images
        while (n_loads + n_reads < 1100) begin
            drain();
            calm = ($urandom_range(0, 3) == 0);
            set_shape(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8),
                      ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8),
                      $urandom_range(0, 15));
            run_image();
        end

        drain();
        $display("covered %0d images, %0d loads and %0d reads", n_images, n_loads, n_reads);
        $display("with %0d register writes, clamped shapes and kernel counts 0 to 15", n_cfg);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // watchdog
    initial begin
        #30_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire
